@@ sv/yuvbl_pkg.sv @@
// ----------------------------------------------------------------------------
// yuvbl_pkg
// shared types and constants for the bilinear yuv to rgba pixel pipeline
// ----------------------------------------------------------------------------
package yuvbl_pkg;

  // per-stage load enables, one bit per register stage
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  typedef logic [7:0]         byte_t;
  typedef logic signed [19:0] mat_t;

  // bilinear blend
  localparam int unsigned FRAC_ONE  = 256;
  localparam int unsigned BLEND_RND = 32768;

  // bt.601 integer matrix
  localparam int unsigned Y_OFFSET  = 16;
  localparam int unsigned C_OFFSET  = 128;
  localparam int unsigned K_Y       = 298;
  localparam int          K_RV      = 409;
  localparam int          K_GU      = 100;
  localparam int          K_GV      = 208;
  localparam int          K_BU      = 516;
  localparam int          MAT_RND   = 128;
  localparam byte_t       ALPHA_OPAQUE = 8'hFF;

endpackage

@@ sv/yuv_bilinear_to_rgba_pixel.sv @@
// ----------------------------------------------------------------------------
// yuv_bilinear_to_rgba_pixel
// bilinear 4:2:0 neighborhood to one rgba pixel, integer bt.601
// ----------------------------------------------------------------------------
//
// channel | direction | tdata bits | contents
// --------+-----------+------------+---------------------------------------
// in_     | slave     | 128        | luma corners, u quad, v quad, fractions
// out_    | master    | 32         | red, green, blue, alpha
//
// four register stages: row blend, column blend, matrix products, sums and
// clamp; an accepted word passes through them in that order, and out_tvalid
// is the stage 4 valid bit; one word per cycle sustained while out_tready
// is high; every stage holds one word and loads when it is empty or its
// successor moves, so bubbles close up under a stall
// out_tready low backs up stage by stage; nothing is dropped or repeated
// rst_n (synchronous, active low) clears the stage valid bits only
//
module yuv_bilinear_to_rgba_pixel
  import yuvbl_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // luma_top_left[7:0], luma_top_right[15:8], luma_bottom_left[23:16],
  // luma_bottom_right[31:24], u_quad[63:32], v_quad[95:64],
  // luma_frac_x[103:96], luma_frac_y[111:104], chroma_frac_x[119:112],
  // chroma_frac_y[127:120]
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  output logic [31:0]  out_tdata
);

  // stage valid bits
  logic      v1_r, v2_r, v3_r, v4_r;
  logic      v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic      rdy1, rdy2, rdy3, rdy4;
  stage_en_t en;

  // unpacked input word
  byte_t luma_tl, luma_tr, luma_bl, luma_br;
  logic [31:0] u_quad, v_quad;
  byte_t luma_fx, luma_fy, chroma_fx, chroma_fy;

  // blend results feeding the matrix
  byte_t y_b, u_b, v_b;
  byte_t red, green, blue;

  assign luma_tl   = in_tdata[7:0];
  assign luma_tr   = in_tdata[15:8];
  assign luma_bl   = in_tdata[23:16];
  assign luma_br   = in_tdata[31:24];
  assign u_quad    = in_tdata[63:32];
  assign v_quad    = in_tdata[95:64];
  assign luma_fx   = in_tdata[103:96];
  assign luma_fy   = in_tdata[111:104];
  assign chroma_fx = in_tdata[119:112];
  assign chroma_fy = in_tdata[127:120];

  // ready ripples back from the output register
  assign rdy4 = !v4_r || out_tready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;
  assign en.s4 = rdy4;

  assign in_tready = rdy1;

  assign v1_nxt = rdy1 ? in_tvalid : v1_r;
  assign v2_nxt = rdy2 ? v1_r      : v2_r;
  assign v3_nxt = rdy3 ? v2_r      : v3_r;
  assign v4_nxt = rdy4 ? v3_r      : v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // stages 1-2: one blend per plane, chroma shares its fractions
  yuvbl_blend u_blend_y (
    .clk     (clk),
    .en      (en),
    .tl      (luma_tl),
    .tr      (luma_tr),
    .bl      (luma_bl),
    .br      (luma_br),
    .fx      (luma_fx),
    .fy      (luma_fy),
    .value_r (y_b)
  );

  yuvbl_blend u_blend_u (
    .clk     (clk),
    .en      (en),
    .tl      (u_quad[7:0]),
    .tr      (u_quad[15:8]),
    .bl      (u_quad[23:16]),
    .br      (u_quad[31:24]),
    .fx      (chroma_fx),
    .fy      (chroma_fy),
    .value_r (u_b)
  );

  yuvbl_blend u_blend_v (
    .clk     (clk),
    .en      (en),
    .tl      (v_quad[7:0]),
    .tr      (v_quad[15:8]),
    .bl      (v_quad[23:16]),
    .br      (v_quad[31:24]),
    .fx      (chroma_fx),
    .fy      (chroma_fy),
    .value_r (v_b)
  );

  // stages 3-4: color matrix, stage 4 is the output register
  yuvbl_matrix u_matrix (
    .clk     (clk),
    .en      (en),
    .y       (y_b),
    .u       (u_b),
    .v       (v_b),
    .red_r   (red),
    .green_r (green),
    .blue_r  (blue)
  );

  assign out_tvalid = v4_r;
  assign out_tdata  = {ALPHA_OPAQUE, blue, green, red};

  // an accepted word always lands in stage 1
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v1_r)
    else $error("accepted word did not reach stage 1");

  // an empty first stage never refuses input
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> in_tready)
    else $error("stage 1 empty but input stalled");

  // a full pipe with a stalled output must stall the input
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && v2_r && v3_r && v4_r && !out_tready |-> !in_tready)
    else $error("input accepted while pipe full and stalled");

  // a word in stage 3 moves on when the output drains
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && out_tready |=> v4_r)
    else $error("stage 3 word lost on drain");

endmodule

@@ sv/yuvbl_blend.sv @@
// ----------------------------------------------------------------------------
// yuvbl_blend
// two-stage bilinear blend of one plane: row blend, then column blend
// ----------------------------------------------------------------------------
module yuvbl_blend
  import yuvbl_pkg::*;
(
  input  logic      clk,
  input  stage_en_t en,
  input  byte_t     tl,
  input  byte_t     tr,
  input  byte_t     bl,
  input  byte_t     br,
  input  byte_t     fx,
  input  byte_t     fy,
  output byte_t     value_r
);

  logic [8:0]  ix;
  logic [16:0] top_sum;
  logic [16:0] bot_sum;
  logic [15:0] top_r;
  logic [15:0] bot_r;
  byte_t       fy_r;
  logic [8:0]  iy;
  logic [24:0] vert_sum;

  // stage 1: horizontal weights
  assign ix      = 9'(FRAC_ONE) - {1'b0, fx};
  assign top_sum = 17'({1'b0, tl} * ix) + 17'({1'b0, tr} * {1'b0, fx});
  assign bot_sum = 17'({1'b0, bl} * ix) + 17'({1'b0, br} * {1'b0, fx});

  always_ff @(posedge clk) begin
    if (en.s1) begin
      top_r <= top_sum[15:0];
      bot_r <= bot_sum[15:0];
      fy_r  <= fy;
    end
  end

  // stage 2: vertical weights and rounding
  assign iy       = 9'(FRAC_ONE) - {1'b0, fy_r};
  assign vert_sum = 25'({9'd0, top_r} * {16'd0, iy}) + 25'({9'd0, bot_r} * {17'd0, fy_r})
                  + 25'(BLEND_RND);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      value_r <= vert_sum[23:16];
    end
  end

endmodule

@@ sv/yuvbl_matrix.sv @@
// ----------------------------------------------------------------------------
// yuvbl_matrix
// two-stage bt.601 color matrix: products, then sums with clamp
// ----------------------------------------------------------------------------
module yuvbl_matrix
  import yuvbl_pkg::*;
(
  input  logic      clk,
  input  stage_en_t en,
  input  byte_t     y,
  input  byte_t     u,
  input  byte_t     v,
  output byte_t     red_r,
  output byte_t     green_r,
  output byte_t     blue_r
);

  byte_t      ym;
  mat_t       u_c;
  mat_t       v_c;
  logic [16:0] lum_r;
  mat_t       rv_r;
  mat_t       gu_r;
  mat_t       gv_r;
  mat_t       bu_r;
  mat_t       lum_s;
  mat_t       r_sum;
  mat_t       g_sum;
  mat_t       b_sum;

  // floor shift by 8, then clamp to byte range
  function automatic byte_t clamp_byte(input mat_t s);
    byte_t res;
    if (s[19]) begin
      res = 8'd0;
    end else if (|s[18:16]) begin
      res = 8'hFF;
    end else begin
      res = s[15:8];
    end
    return res;
  endfunction

  // stage 3: offsets and constant products
  assign ym  = (y < 8'(Y_OFFSET)) ? 8'd0 : y - 8'(Y_OFFSET);
  assign u_c = $signed({12'd0, u}) - 20'sd128;
  assign v_c = $signed({12'd0, v}) - 20'sd128;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      lum_r <= 17'({9'd0, ym} * 17'(K_Y));
      rv_r  <= 20'(v_c * 20'(K_RV));
      gu_r  <= 20'(u_c * 20'(K_GU));
      gv_r  <= 20'(v_c * 20'(K_GV));
      bu_r  <= 20'(u_c * 20'(K_BU));
    end
  end

  // stage 4: channel sums and clamp
  assign lum_s = $signed({3'd0, lum_r});
  assign r_sum = lum_s + rv_r + 20'(MAT_RND);
  assign g_sum = lum_s - gu_r - gv_r + 20'(MAT_RND);
  assign b_sum = lum_s + bu_r + 20'(MAT_RND);

  always_ff @(posedge clk) begin
    if (en.s4) begin
      red_r   <= clamp_byte(r_sum);
      green_r <= clamp_byte(g_sum);
      blue_r  <= clamp_byte(b_sum);
    end
  end

endmodule

@@ tb/rgba_pixel_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba_pixel_checker
// watches both stream channels, predicts each rgba pixel from the accepted
// neighborhood word and compares it field by field with the returned word
// ----------------------------------------------------------------------------
module rgba_pixel_checker
  import yuvbl_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [31:0]  out_tdata,
  output int           mismatch_count,
  output int           pixels_pending,
  output int           pixels_checked
);

  // first member sits in the top bits, so red lands at [7:0]
  typedef struct packed {
    byte_t alpha;
    byte_t blue;
    byte_t green;
    byte_t red;
  } rgba_t;

  rgba_t expected_pixels[$];

  // q8 bilinear blend of four corner samples, rounded
  function automatic byte_t blend_corners(byte_t tl, byte_t tr, byte_t bl, byte_t br,
                                          byte_t fx, byte_t fy);
    int unsigned ix, iy, top_row, bot_row;
    ix      = FRAC_ONE - fx;
    iy      = FRAC_ONE - fy;
    top_row = tl * ix + tr * fx;
    bot_row = bl * ix + br * fx;
    return byte_t'((top_row * iy + bot_row * fy + BLEND_RND) >> 16);
  endfunction

  // floor shift by 8, then saturate to a byte
  function automatic byte_t clamp_channel(int sum);
    int q;
    q = sum >>> 8;
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return byte_t'(q);
  endfunction

  function automatic rgba_t predict_pixel(logic [127:0] w);
    byte_t y_blend, u_blend, v_blend;
    int    u, v, y_off, lum;
    rgba_t px;
    y_blend = blend_corners(w[7:0], w[15:8], w[23:16], w[31:24], w[103:96], w[111:104]);
    u_blend = blend_corners(w[39:32], w[47:40], w[55:48], w[63:56],
                            w[119:112], w[127:120]);
    v_blend = blend_corners(w[71:64], w[79:72], w[87:80], w[95:88],
                            w[119:112], w[127:120]);
    u     = int'(u_blend) - int'(C_OFFSET);
    v     = int'(v_blend) - int'(C_OFFSET);
    y_off = int'(y_blend) - int'(Y_OFFSET);
    if (y_off < 0) y_off = 0;
    lum      = y_off * int'(K_Y);
    px.red   = clamp_channel(lum + K_RV * v + MAT_RND);
    px.green = clamp_channel(lum - K_GU * u - K_GV * v + MAT_RND);
    px.blue  = clamp_channel(lum + K_BU * u + MAT_RND);
    px.alpha = ALPHA_OPAQUE;
    return px;
  endfunction

  initial begin
    mismatch_count = 0;
    pixels_pending = 0;
    pixels_checked = 0;
  end

  always @(posedge clk) begin
    rgba_t exp_px;
    rgba_t got_px;
    if (rst_n) begin
      if (in_tvalid && in_tready) expected_pixels.push_back(predict_pixel(in_tdata));
      if (out_tvalid && out_tready) begin
        got_px = out_tdata;
        if (expected_pixels.size() == 0) begin
          $error("unexpected output word %h with no pixel pending", out_tdata);
          mismatch_count <= mismatch_count + 1;
        end else begin
          exp_px = expected_pixels.pop_front();
          if (got_px.red != exp_px.red)
            $error("red: expected %0d, got %0d", exp_px.red, got_px.red);
          if (got_px.green != exp_px.green)
            $error("green: expected %0d, got %0d", exp_px.green, got_px.green);
          if (got_px.blue != exp_px.blue)
            $error("blue: expected %0d, got %0d", exp_px.blue, got_px.blue);
          if (got_px.alpha != exp_px.alpha)
            $error("alpha: expected %0d, got %0d", exp_px.alpha, got_px.alpha);
          if (got_px != exp_px) mismatch_count <= mismatch_count + 1;
          pixels_checked <= pixels_checked + 1;
        end
      end
      pixels_pending <= expected_pixels.size();
    end
  end

endmodule

@@ tb/yuv_bilinear_to_rgba_pixel_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv_bilinear_to_rgba_pixel_tb
// drives neighborhood words into the bilinear yuv to rgba pipeline under
// three flow-control mixes and lets the checker score every output pixel
// ----------------------------------------------------------------------------
module yuv_bilinear_to_rgba_pixel_tb;
  import yuvbl_pkg::*;

  localparam int RANDOM_PER_PHASE = 600;   // three phases, about 1800 words
  localparam int QUIET_LIMIT      = 4000;  // cycles with no handshake at all
  localparam int TAIL_CYCLES      = 16;    // pipeline is 4 deep, leave margin

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // luma_top_left[7:0], luma_top_right[15:8], luma_bottom_left[23:16],
  // luma_bottom_right[31:24], u_quad[63:32], v_quad[95:64],
  // luma_frac_x[103:96], luma_frac_y[111:104], chroma_frac_x[119:112],
  // chroma_frac_y[127:120]
  logic [127:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  logic [31:0]  out_tdata;

  int mismatch_count;
  int pixels_pending;
  int pixels_checked;

  // idle odds in percent per cycle, changed per phase
  int send_idle_pct;
  int recv_stall_pct;

  int directed_sent;
  int random_sent;
  int quiet_cycles;

  yuv_bilinear_to_rgba_pixel dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  rgba_pixel_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .pixels_pending (pixels_pending),
    .pixels_checked (pixels_checked)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: one draw per cycle against the current stall odds
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: a correct run never goes this long without a handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // pack fields into the input word, first field lowest
  function automatic logic [127:0] make_word(byte_t tl, byte_t tr, byte_t bl, byte_t br,
                                             logic [31:0] u_quad, logic [31:0] v_quad,
                                             byte_t lfx, byte_t lfy, byte_t cfx, byte_t cfy);
    return {cfy, cfx, lfy, lfx, v_quad, u_quad, br, bl, tr, tl};
  endfunction

  // samples lean toward the rails and near-black so clamps and floors get hit
  function automatic byte_t pick_sample();
    case ($urandom_range(15))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return byte_t'($urandom_range(20));
      3:       return byte_t'(255 - $urandom_range(20));
      default: return byte_t'($urandom_range(255));
    endcase
  endfunction

  // fractions lean toward zero, one and one half
  function automatic byte_t pick_frac();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd128;
      default: return byte_t'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [31:0] pick_quad();
    byte_t s;
    // flat chroma patch now and then, otherwise four independent samples
    if ($urandom_range(7) == 0) begin
      s = pick_sample();
      return {s, s, s, s};
    end
    return {pick_sample(), pick_sample(), pick_sample(), pick_sample()};
  endfunction

  function automatic logic [127:0] random_word();
    if ($urandom_range(3) == 0) return {$urandom, $urandom, $urandom, $urandom};
    return make_word(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                     pick_quad(), pick_quad(),
                     pick_frac(), pick_frac(), pick_frac(), pick_frac());
  endfunction

  // offer one word, with random idle cycles ahead of it, and wait for accept
  task automatic push_pixel(input logic [127:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // hold off the sender until every pixel in flight has come back
  task automatic drain_pixels();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
  endtask

  task automatic push_directed(input logic [127:0] word);
    push_pixel(word);
    directed_sent++;
  endtask

  initial begin
    int phase;
    int i;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    send_idle_pct  = 11;
    recv_stall_pct = 78;
    directed_sent  = 0;
    random_sent    = 0;
    quiet_cycles   = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners of the arithmetic
    // everything zero: luma floors, chroma at its most negative
    push_directed(make_word(0, 0, 0, 0, 32'h0, 32'h0, 0, 0, 0, 0));
    // everything at full scale
    push_directed(make_word(255, 255, 255, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            255, 255, 255, 255));
    // zero fractions pick the top-left sample exactly
    push_directed(make_word(8'h5A, 8'hC3, 8'h11, 8'hEE, 32'h20F0_4090, 32'h7F01_C36B,
                            0, 0, 0, 0));
    // fractions at 255 lean almost fully to the bottom-right
    push_directed(make_word(8'h5A, 8'hC3, 8'h11, 8'hEE, 32'h20F0_4090, 32'h7F01_C36B,
                            255, 255, 255, 255));
    // midpoint blend
    push_directed(make_word(0, 255, 255, 0, 32'h00FF_FF00, 32'hFF00_00FF,
                            128, 128, 128, 128));
    // video-range white and black with neutral chroma
    push_directed(make_word(235, 235, 235, 235, 32'h8080_8080, 32'h8080_8080,
                            8'h37, 8'h91, 8'h0C, 8'hE4));
    push_directed(make_word(16, 16, 16, 16, 32'h8080_8080, 32'h8080_8080,
                            8'h37, 8'h91, 8'h0C, 8'hE4));
    // luma below the offset floors at zero
    push_directed(make_word(5, 9, 0, 15, 32'h8080_8080, 32'h8080_8080, 64, 192, 0, 0));
    // red pushed over the top, then below zero
    push_directed(make_word(235, 235, 235, 235, 32'h8080_8080, 32'hFFFF_FFFF, 0, 0, 0, 0));
    push_directed(make_word(16, 16, 16, 16, 32'h8080_8080, 32'h0, 0, 0, 0, 0));
    // blue over the top, then below zero
    push_directed(make_word(235, 235, 235, 235, 32'hFFFF_FFFF, 32'h8080_8080, 0, 0, 0, 0));
    push_directed(make_word(16, 16, 16, 16, 32'h0, 32'h8080_8080, 0, 0, 0, 0));
    // green over the top, then below zero
    push_directed(make_word(255, 255, 255, 255, 32'h0, 32'h0, 0, 0, 0, 0));
    push_directed(make_word(0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0));
    // one axis at full weight, the other at none
    push_directed(make_word(10, 200, 30, 250, 32'h40C0_10F0, 32'hF010_C040,
                            255, 0, 0, 255));
    push_directed(make_word(10, 200, 30, 250, 32'h40C0_10F0, 32'hF010_C040,
                            0, 255, 255, 0));
    // walking and alternating bit patterns
    push_directed(make_word(8'h01, 8'h02, 8'h04, 8'h80, 32'h55AA_55AA, 32'hAA55_AA55,
                            8'h01, 8'h80, 8'h7F, 8'hFE));
    push_directed(make_word(8'hFE, 8'hFD, 8'hFB, 8'h7F, 32'hAA55_AA55, 32'h55AA_55AA,
                            8'hFE, 8'h7F, 8'h80, 8'h01));

    // random phases: sender light / receiver heavy, swapped, then no idling
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 11;
          recv_stall_pct = 78;
        end
        1: begin
          send_idle_pct  = 78;
          recv_stall_pct = 11;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      drain_pixels();
      for (i = 0; i < RANDOM_PER_PHASE; i++) begin
        // a second full drain in the middle of each phase
        if (i == RANDOM_PER_PHASE / 2) drain_pixels();
        push_pixel(random_word());
        random_sent++;
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pixels_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (pixels_pending != 0) $error("%0d pixels never came back", pixels_pending);
    $display("sent %0d directed and %0d random neighborhoods, %0d pixels compared",
             directed_sent, random_sent, pixels_checked);
    $display("flow control: sender-light, receiver-light and back-to-back phases");
    if (mismatch_count == 0 && pixels_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
